// ===== design/rpsc_pkg.sv =====
// Shared types, constants and lookup functions for the radar scan converter.
// Used by rpsc_front, rpsc_queue, rpsc_back and radar_polar_scan_convert_top.
`timescale 1ns / 1ps
`default_nettype none

package rpsc_pkg;

    // Input and output field widths
    localparam int AZ_W     = 9;
    localparam int GATE_W   = 10;
    localparam int REFL_W   = 16;
    localparam int PIX_W    = 13;
    localparam int CENTER_W = 11;
    localparam int GLEN_W   = 10;
    localparam int CFG_W    = 11;
    localparam int SIN_W    = 18;   // signed Q2.16, magnitude up to 65536
    localparam int RGBA_W   = 32;

    // Configuration register indexes
    localparam logic REG_CENTER   = 1'b0;
    localparam logic REG_GATE_LEN = 1'b1;

    localparam logic [CENTER_W-1:0] CENTER_RESET   = CENTER_W'(460);
    localparam logic [GLEN_W-1:0]   GATE_LEN_RESET = GLEN_W'(1000);

    localparam int MAX_GATES    = 1024;
    localparam int ANGLE_STEPS  = 360;
    localparam int QUARTER_DEG  = 90;
    localparam int QUEUE_DEPTH  = 2;

    // Projection: trunc((r_num*S + ROUND_BIAS) / (65536*1000))
    localparam int ROUND_BIAS   = 32768000;
    localparam int DIV_SHIFT    = 16;
    localparam int DIV_LO       = 1000;
    localparam int RECIP_LO     = 1048;   // floor(2^20 / 1000), never overshoots
    localparam int RECIP_SHIFT  = 20;

    typedef struct packed {
        logic signed [SIN_W-1:0] sin_x;
        logic signed [SIN_W-1:0] sin_y;
        logic [GATE_W-1:0]       gate;
        logic [RGBA_W-1:0]       rgba;
    } t_job;

    localparam logic [16:0] QUARTER_SINE [0:90] = '{
        17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
        17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
        17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
        17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
        17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
        17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
        17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
        17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
        17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
        17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
        17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
        17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
        17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
    };

    // Upper band edges in tenths of dBZ
    localparam logic signed [REFL_W-1:0] BAND_LIMIT [0:15] = '{
        -16'sd50, 16'sd0,   16'sd50,  16'sd100, 16'sd150, 16'sd200, 16'sd250, 16'sd300,
        16'sd350, 16'sd400, 16'sd450, 16'sd500, 16'sd550, 16'sd600, 16'sd650, 16'sd9000
    };

    // {red, green, blue, alpha}; entry zero is the transparent color
    localparam logic [RGBA_W-1:0] BAND_COLOR [0:15] = '{
        32'h00000000, 32'h00ACA4FF, 32'hC0C0FEFF, 32'h7072EEFF,
        32'h1E26D0FF, 32'hA6FCA8FF, 32'h00EA00FF, 32'h10921AFF,
        32'hFCF464FF, 32'hC8C802FF, 32'h8C8C00FF, 32'hFEACACFF,
        32'hFE645CFF, 32'hEE0230FF, 32'hD48EFEFF, 32'hAA24FAFF
    };

    // Angle must already be below ANGLE_STEPS
    function automatic logic signed [SIN_W-1:0] sine_q16(input logic [AZ_W-1:0] a);
        logic [6:0]  m;
        logic        mirror;
        logic        neg;
        logic [16:0] v;
        if (a >= AZ_W'(3 * QUARTER_DEG)) begin
            m = 7'(a - AZ_W'(3 * QUARTER_DEG));
            mirror = 1'b1;
            neg = 1'b1;
        end else if (a >= AZ_W'(2 * QUARTER_DEG)) begin
            m = 7'(a - AZ_W'(2 * QUARTER_DEG));
            mirror = 1'b0;
            neg = 1'b1;
        end else if (a >= AZ_W'(QUARTER_DEG)) begin
            m = 7'(a - AZ_W'(QUARTER_DEG));
            mirror = 1'b1;
            neg = 1'b0;
        end else begin
            m = 7'(a);
            mirror = 1'b0;
            neg = 1'b0;
        end
        v = mirror ? QUARTER_SINE[7'(QUARTER_DEG) - m] : QUARTER_SINE[m];
        return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // Out-of-range reflectivity on either side maps to the transparent color
    function automatic logic [RGBA_W-1:0] band_color(input logic signed [REFL_W-1:0] refl);
        logic [3:0] idx;
        idx = 4'd0;
        for (int k = 15; k >= 1; k--) begin
            if (refl < BAND_LIMIT[k]) begin
                idx = 4'(k);
            end
        end
        if (refl < BAND_LIMIT[0]) begin
            idx = 4'd0;
        end
        return BAND_COLOR[idx];
    endfunction

endpackage

`default_nettype wire

// ===== design/rpsc_front.sv =====
// Front end: accepts samples, reduces the azimuth, looks up sine and cosine,
// saturates the gate and picks the palette color. Depends on rpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpsc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [rpsc_pkg::AZ_W-1:0]    i_azimuth_deg,
    input  wire logic [rpsc_pkg::GATE_W-1:0]  i_gate_index,
    input  wire logic signed [rpsc_pkg::REFL_W-1:0] i_reflectivity,
    output logic                              o_push,
    output rpsc_pkg::t_job                    o_job,
    input  wire logic                         i_full
);
    import rpsc_pkg::*;

    logic           r_valid;
    t_job           r_job;
    t_job           n_job;
    logic [AZ_W-1:0] az_red;
    logic [AZ_W:0]   cos_sum;
    logic [AZ_W-1:0] cos_idx;
    logic            accept;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_job   = r_job;

    always_comb begin
        az_red = (i_azimuth_deg >= AZ_W'(ANGLE_STEPS)) ?
                 i_azimuth_deg - AZ_W'(ANGLE_STEPS) : i_azimuth_deg;
        cos_sum = {1'b0, az_red} + (AZ_W+1)'(QUARTER_DEG);
        if (cos_sum >= (AZ_W+1)'(ANGLE_STEPS)) begin
            cos_sum = cos_sum - (AZ_W+1)'(ANGLE_STEPS);
        end
        cos_idx = cos_sum[AZ_W-1:0];

        n_job.sin_x = sine_q16(az_red);
        n_job.sin_y = -sine_q16(cos_idx);
        if (32'(i_gate_index) >= MAX_GATES) begin
            n_job.gate = GATE_W'(MAX_GATES - 1);
        end else begin
            n_job.gate = i_gate_index;
        end
        n_job.rgba = band_color(i_reflectivity);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // hold the classified item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

// ===== design/rpsc_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on rpsc_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module rpsc_queue #(
    parameter int DEPTH = rpsc_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rpsc_pkg::t_job i_item,
    output logic                o_full,
    output logic                o_valid,
    output rpsc_pkg::t_job      o_item,
    input  wire logic           i_pop
);
    import rpsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/rpsc_back.sv =====
// Back end: seven-stage projection pipeline (range multiply, sine multiply,
// rounding, divide by 65536000 by reciprocal, centering). Depends on rpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpsc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_valid,
    input  wire rpsc_pkg::t_job                i_job,
    output logic                               o_pop,
    input  wire logic [rpsc_pkg::CENTER_W-1:0] i_center,
    input  wire logic [rpsc_pkg::GLEN_W-1:0]   i_gate_len,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [rpsc_pkg::PIX_W-1:0]  o_pixel_x,
    output logic signed [rpsc_pkg::PIX_W-1:0]  o_pixel_y,
    output logic [rpsc_pkg::RGBA_W-1:0]        o_rgba,
    output logic                               o_in_image
);
    import rpsc_pkg::*;

    localparam int RNUM_W = GLEN_W + GATE_W;          // 20
    localparam int PROD_W = RNUM_W + 1 + SIN_W;       // 39
    localparam int M16_W  = PROD_W - 1 - DIV_SHIFT;   // 22
    localparam int RP_W   = M16_W + 11;               // 33
    localparam int Q_W    = 12;
    localparam int NST    = 7;

    logic [NST:1]                   r_v;
    logic                           en;
    logic [RGBA_W-1:0]              r_col  [1:NST];
    logic [RNUM_W-1:0]              r_rnum;
    logic signed [SIN_W-1:0]        r_sin  [0:1];
    logic signed [PROD_W-1:0]       r_prod [0:1];
    logic                           r_neg3 [0:1];
    logic [M16_W-1:0]               r_m16_3 [0:1];
    logic                           r_neg4 [0:1];
    logic [M16_W-1:0]               r_m16_4 [0:1];
    logic [Q_W-1:0]                 r_q0_4 [0:1];
    logic                           r_neg5 [0:1];
    logic [M16_W-1:0]               r_m16_5 [0:1];
    logic [Q_W-1:0]                 r_q0_5 [0:1];
    logic [M16_W-1:0]               r_q0x_5 [0:1];
    logic signed [PIX_W-1:0]        r_sq6  [0:1];
    logic signed [PIX_W-1:0]        r_pix  [0:1];
    logic                           r_in_img;

    logic signed [PROD_W-1:0]       n_t    [0:1];
    logic [PROD_W-1:0]              n_mag  [0:1];
    logic [RP_W-1:0]                n_rp   [0:1];
    logic [M16_W-1:0]               n_rem  [0:1];
    logic [Q_W-1:0]                 n_q    [0:1];
    logic signed [PIX_W-1:0]        n_pix  [0:1];
    logic signed [PIX_W+1:0]        side;
    logic                           n_inside [0:1];

    // advance the whole pipe unless the output holds an untaken item
    assign en    = !r_v[NST] || i_ready;
    assign o_pop = en && i_job_valid;

    assign o_valid    = r_v[NST];
    assign o_pixel_x  = r_pix[0];
    assign o_pixel_y  = r_pix[1];
    assign o_rgba     = r_col[NST];
    assign o_in_image = r_in_img;

    assign side = $signed({3'b000, i_center, 1'b0});

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_t[l]   = r_prod[l] + PROD_W'(ROUND_BIAS);
            n_mag[l] = n_t[l][PROD_W-1] ? PROD_W'(-n_t[l]) : PROD_W'(n_t[l]);
            n_rp[l]  = RP_W'(r_m16_3[l]) * RP_W'(RECIP_LO);
            n_rem[l] = r_m16_5[l] - r_q0x_5[l];
            n_q[l]   = (n_rem[l] >= M16_W'(DIV_LO)) ? r_q0_5[l] + 1'b1 : r_q0_5[l];
            n_pix[l] = r_sq6[l] + $signed({2'b00, i_center});
            n_inside[l] = !n_pix[l][PIX_W-1] &&
                          ($signed({{2{n_pix[l][PIX_W-1]}}, n_pix[l]}) < side);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-1:1], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // range numerator in metres
            r_rnum   <= RNUM_W'(i_gate_len) * RNUM_W'(i_job.gate);
            r_sin[0] <= i_job.sin_x;
            r_sin[1] <= i_job.sin_y;
            r_col[1] <= i_job.rgba;
            for (int s = 2; s <= NST; s++) begin
                r_col[s] <= r_col[s-1];
            end
            for (int l = 0; l < 2; l++) begin
                r_prod[l]  <= PROD_W'($signed({1'b0, r_rnum})) * PROD_W'(r_sin[l]);
                // magnitude then floor by 65536, sign restored after the divide
                r_neg3[l]  <= n_t[l][PROD_W-1];
                r_m16_3[l] <= n_mag[l][PROD_W-2:DIV_SHIFT];
                r_neg4[l]  <= r_neg3[l];
                r_m16_4[l] <= r_m16_3[l];
                r_q0_4[l]  <= n_rp[l][RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
                r_neg5[l]  <= r_neg4[l];
                r_m16_5[l] <= r_m16_4[l];
                r_q0_5[l]  <= r_q0_4[l];
                r_q0x_5[l] <= M16_W'(r_q0_4[l]) * M16_W'(DIV_LO);
                // correct the reciprocal estimate by one, then apply the sign
                r_sq6[l]   <= r_neg5[l] ? -$signed(PIX_W'(n_q[l])) : $signed(PIX_W'(n_q[l]));
                r_pix[l]   <= n_pix[l];
            end
            r_in_img <= n_inside[0] && n_inside[1];
        end
    end

endmodule

`default_nettype wire

// ===== design/radar_polar_scan_convert_top.sv =====
// Radar PPI scan converter: one sample in, one pixel with RGBA color out.
// Throughput: one item per cycle when the pixel side is ready. An accepted sample passes
// through the front register, the queue and seven back-end stages to the output.
// Reset (synchronous, active low) empties front, queue and pipe and loads
// center_offset = 460 and gate_length_m = 1000. Depends on rpsc_pkg and submodules.
`timescale 1ns / 1ps
`default_nettype none

module radar_polar_scan_convert_top #(
    parameter int QUEUE_DEPTH = rpsc_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_index,
    input  wire logic [rpsc_pkg::CFG_W-1:0]         i_cfg_data,
    // sample channel
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [rpsc_pkg::AZ_W-1:0]          i_azimuth_deg,
    input  wire logic [rpsc_pkg::GATE_W-1:0]        i_gate_index,
    input  wire logic signed [rpsc_pkg::REFL_W-1:0] i_reflectivity,
    // pixel channel
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [rpsc_pkg::PIX_W-1:0]       o_pixel_x,
    output logic signed [rpsc_pkg::PIX_W-1:0]       o_pixel_y,
    output logic [7:0]                              o_red,
    output logic [7:0]                              o_green,
    output logic [7:0]                              o_blue,
    output logic [7:0]                              o_alpha,
    output logic                                    o_in_image
);
    import rpsc_pkg::*;

    logic [CENTER_W-1:0] r_center;
    logic [GLEN_W-1:0]   r_gate_len;

    logic        front_push;
    t_job        front_job;
    logic        queue_full;
    logic        queue_valid;
    t_job        queue_job;
    logic        back_pop;
    logic [RGBA_W-1:0] rgba;

    // config registers: the user must write them only while the block is idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= CENTER_RESET;
            r_gate_len <= GATE_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CENTER:   r_center   <= i_cfg_data[CENTER_W-1:0];
                REG_GATE_LEN: r_gate_len <= i_cfg_data[GLEN_W-1:0];
                default:      r_center   <= r_center;
            endcase
        end
    end

    // classify: reduce angle, table lookups, palette band
    rpsc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_azimuth_deg  (i_azimuth_deg),
        .i_gate_index   (i_gate_index),
        .i_reflectivity (i_reflectivity),
        .o_push         (front_push),
        .o_job          (front_job),
        .i_full         (queue_full)
    );

    // decouple front from back so each can stall on its own
    rpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (queue_job),
        .i_pop   (back_pop)
    );

    // project to pixel coordinates; last stage is the output register
    rpsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_pop       (back_pop),
        .i_center    (r_center),
        .i_gate_len  (r_gate_len),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_rgba      (rgba),
        .o_in_image  (o_in_image)
    );

    assign o_red   = rgba[31:24];
    assign o_green = rgba[23:16];
    assign o_blue  = rgba[15:8];
    assign o_alpha = rgba[7:0];

endmodule

`default_nettype wire

// ===== sim/rpsc_pixel_checker.sv =====
// Pixel checker for the radar scan converter: watches the sample and pixel channels,
// predicts each pixel from its own sine table and palette, and counts mismatches.
// Depends on rpsc_pkg for port widths, register indexes and reset values.
`timescale 1ns / 1ps

module rpsc_pixel_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_index,
    input  wire logic [rpsc_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic [rpsc_pkg::AZ_W-1:0]          i_azimuth_deg,
    input  wire logic [rpsc_pkg::GATE_W-1:0]        i_gate_index,
    input  wire logic signed [rpsc_pkg::REFL_W-1:0] i_reflectivity,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic signed [rpsc_pkg::PIX_W-1:0]  i_pixel_x,
    input  wire logic signed [rpsc_pkg::PIX_W-1:0]  i_pixel_y,
    input  wire logic [7:0]                         i_red,
    input  wire logic [7:0]                         i_green,
    input  wire logic [7:0]                         i_blue,
    input  wire logic [7:0]                         i_alpha,
    input  wire logic                               i_in_image,
    output int                                      o_mismatches,
    output int                                      o_pending
);

    typedef struct {
        logic signed [rpsc_pkg::PIX_W-1:0] px;
        logic signed [rpsc_pkg::PIX_W-1:0] py;
        logic [31:0]                       rgba;
        logic                              in_img;
    } t_pixel;

    // round(65536 * sin(k deg)) for k = 0..90
    localparam int QSINE [0:90] = '{
        0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
        11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    // Band k holds reflectivity below BAND_TOP[k]; colors are {r, g, b, a}
    localparam int BAND_TOP [0:15] = '{
        -50, 0, 50, 100, 150, 200, 250, 300, 350, 400, 450, 500, 550, 600, 650, 9000
    };
    localparam logic [31:0] BAND_RGBA [0:15] = '{
        32'h00000000, 32'h00ACA4FF, 32'hC0C0FEFF, 32'h7072EEFF,
        32'h1E26D0FF, 32'hA6FCA8FF, 32'h00EA00FF, 32'h10921AFF,
        32'hFCF464FF, 32'hC8C802FF, 32'h8C8C00FF, 32'hFEACACFF,
        32'hFE645CFF, 32'hEE0230FF, 32'hD48EFEFF, 32'hAA24FAFF
    };

    logic [rpsc_pkg::CENTER_W-1:0] center_q;
    logic [rpsc_pkg::GLEN_W-1:0]   gate_len_q;
    t_pixel                        expected_pixels [$];
    int                            mismatch_count;

    function automatic longint wave(input int unsigned deg);
        int unsigned a;
        int unsigned q;
        int unsigned m;
        longint      v;
        a = deg % 360;
        q = a / 90;
        m = a % 90;
        v = (q % 2 == 1) ? QSINE[90 - m] : QSINE[m];
        return (q >= 2) ? -v : v;
    endfunction

    // trunc(rnum * s / 65536000 + 0.5), toward zero
    function automatic longint round_axis(input longint rnum, input longint s);
        return (rnum * s + 64'sd32768000) / 64'sd65536000;
    endfunction

    function automatic t_pixel predict_pixel(
        input logic [rpsc_pkg::AZ_W-1:0]          az,
        input logic [rpsc_pkg::GATE_W-1:0]        gate,
        input logic signed [rpsc_pkg::REFL_W-1:0] refl
    );
        t_pixel p;
        longint rnum;
        longint x;
        longint y;
        longint side;
        int     level;
        int     idx;
        bit     found;
        rnum  = longint'(gate_len_q) * longint'(gate);
        x     = round_axis(rnum, wave(az)) + longint'(center_q);
        y     = round_axis(rnum, -wave(int'(az) + 90)) + longint'(center_q);
        level = int'(refl);
        idx   = 0;
        found = 1'b0;
        if (level >= BAND_TOP[0]) begin
            for (int k = 1; k < 16; k++) begin
                if (!found && level < BAND_TOP[k]) begin
                    idx   = k;
                    found = 1'b1;
                end
            end
        end
        side     = 2 * longint'(center_q);
        p.px     = x[rpsc_pkg::PIX_W-1:0];
        p.py     = y[rpsc_pkg::PIX_W-1:0];
        p.rgba   = BAND_RGBA[idx];
        p.in_img = (x >= 0 && x < side && y >= 0 && y < side);
        return p;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel want;
        t_pixel got;
        if (!i_rst_n) begin
            center_q       = rpsc_pkg::CENTER_RESET;
            gate_len_q     = rpsc_pkg::GATE_LEN_RESET;
            expected_pixels.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rpsc_pkg::REG_CENTER) begin
                    center_q = i_cfg_data[rpsc_pkg::CENTER_W-1:0];
                end else if (i_cfg_index == rpsc_pkg::REG_GATE_LEN) begin
                    gate_len_q = i_cfg_data[rpsc_pkg::GLEN_W-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_pixels.push_back(
                    predict_pixel(i_azimuth_deg, i_gate_index, i_reflectivity));
            end
            if (i_out_valid && i_out_ready) begin
                got.px     = i_pixel_x;
                got.py     = i_pixel_y;
                got.rgba   = {i_red, i_green, i_blue, i_alpha};
                got.in_img = i_in_image;
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected pixel x=%0d y=%0d rgba=%08h in=%0b",
                                 $realtime, got.px, got.py, got.rgba, got.in_img);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.px !== want.px || got.py !== want.py ||
                        got.rgba !== want.rgba || got.in_img !== want.in_img) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: pixel mismatch exp x=%0d y=%0d rgba=%08h in=%0b",
                                     $realtime, want.px, want.py, want.rgba, want.in_img);
                            $display("%0t:                got x=%0d y=%0d rgba=%08h in=%0b",
                                     $realtime, got.px, got.py, got.rgba, got.in_img);
                        end
                    end
                end
            end
        end
        o_pending    <= expected_pixels.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ===== sim/tb_top.sv =====
// Top of the radar scan converter testbench: clock, reset, register writes,
// sample stimulus and pixel back-pressure, and the final verdict.
// Depends on rpsc_pkg, radar_polar_scan_convert_top and rpsc_pixel_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 16;   // idle time after the final drain
    localparam int CHUNKS        = 8;
    localparam int CHUNK_ITEMS   = 50;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               cfg_we;
    logic                               cfg_index;
    logic [rpsc_pkg::CFG_W-1:0]         cfg_data;
    logic                               smp_valid;
    logic                               smp_ready;
    logic [rpsc_pkg::AZ_W-1:0]          smp_az;
    logic [rpsc_pkg::GATE_W-1:0]        smp_gate;
    logic signed [rpsc_pkg::REFL_W-1:0] smp_refl;
    logic                               pix_valid;
    logic                               pix_ready;
    logic signed [rpsc_pkg::PIX_W-1:0]  pix_x;
    logic signed [rpsc_pkg::PIX_W-1:0]  pix_y;
    logic [7:0]                         pix_red;
    logic [7:0]                         pix_green;
    logic [7:0]                         pix_blue;
    logic [7:0]                         pix_alpha;
    logic                               pix_in_image;

    int mismatches;
    int pending;
    int cycle_count;
    int send_idle_pct;     // chance in a hundred that the sender skips a cycle
    int recv_stall_pct;    // chance in a hundred that the receiver holds off

    // Current register values, kept here only to aim gates at the image edge
    int cur_center;
    int cur_gate_len;

    radar_polar_scan_convert_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (smp_valid),
        .o_ready        (smp_ready),
        .i_azimuth_deg  (smp_az),
        .i_gate_index   (smp_gate),
        .i_reflectivity (smp_refl),
        .o_valid        (pix_valid),
        .i_ready        (pix_ready),
        .o_pixel_x      (pix_x),
        .o_pixel_y      (pix_y),
        .o_red          (pix_red),
        .o_green        (pix_green),
        .o_blue         (pix_blue),
        .o_alpha        (pix_alpha),
        .o_in_image     (pix_in_image)
    );

    rpsc_pixel_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (smp_valid),
        .i_in_ready     (smp_ready),
        .i_azimuth_deg  (smp_az),
        .i_gate_index   (smp_gate),
        .i_reflectivity (smp_refl),
        .i_out_valid    (pix_valid),
        .i_out_ready    (pix_ready),
        .i_pixel_x      (pix_x),
        .i_pixel_y      (pix_y),
        .i_red          (pix_red),
        .i_green        (pix_green),
        .i_blue         (pix_blue),
        .i_alpha        (pix_alpha),
        .i_in_image     (pix_in_image),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Count cycles for the watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL radar_polar_scan_convert_top");
        $finish;
    end

    // Pixel side back-pressure: hold off ready at the rate of the current phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ready <= 1'b0;
        end else begin
            pix_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one sample, with random idle cycles ahead of it, and hold it until
    // accepted. Valid stays high into the next call unless that call idles.
    task automatic push_sample(
        input logic [rpsc_pkg::AZ_W-1:0]          az,
        input logic [rpsc_pkg::GATE_W-1:0]        gate,
        input logic signed [rpsc_pkg::REFL_W-1:0] refl
    );
        while ($urandom_range(99) < send_idle_pct) begin
            smp_valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_valid <= 1'b1;
        smp_az    <= az;
        smp_gate  <= gate;
        smp_refl  <= refl;
        do begin
            @(posedge i_clk);
        end while (!smp_ready);
    endtask

    // Drop valid and wait until every expected pixel has come out
    task automatic drain_pixels();
        smp_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write both registers on back-to-back cycles while the block is idle.
    // The gate length register ignores bit 10 of the data; toggle it anyway.
    task automatic load_registers(input int center, input int gate_len);
        cfg_we    <= 1'b1;
        cfg_index <= rpsc_pkg::REG_CENTER;
        cfg_data  <= rpsc_pkg::CFG_W'(center);
        @(posedge i_clk);
        cfg_index <= rpsc_pkg::REG_GATE_LEN;
        cfg_data  <= {1'($urandom_range(1)), rpsc_pkg::GLEN_W'(gate_len)};
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_center   = center % 2048;
        cur_gate_len = gate_len % 1024;
    endtask

    // Default registers (center 460, gate 1000 m): cardinal and diagonal
    // directions, image edges on each side, angle wrap, palette band edges
    // and the extremes of every field.
    task automatic run_directed();
        push_sample(9'd0,   10'd0,    -16'sd32768);   // origin, most negative
        push_sample(9'd0,   10'd1023, 16'sd32767);    // far north, most positive
        push_sample(9'd90,  10'd459,  -16'sd51);      // just inside east edge
        push_sample(9'd90,  10'd460,  -16'sd50);      // x lands on 2*center
        push_sample(9'd180, 10'd459,  -16'sd1);
        push_sample(9'd180, 10'd460,  16'sd0);        // y lands on 2*center
        push_sample(9'd270, 10'd460,  16'sd49);       // x = 0, still inside
        push_sample(9'd270, 10'd461,  16'sd50);       // x = -1
        push_sample(9'd359, 10'd300,  16'sd649);
        push_sample(9'd45,  10'd200,  16'sd650);
        push_sample(9'd360, 10'd100,  16'sd8999);     // angle wraps to north
        push_sample(9'd511, 10'd700,  16'sd9000);     // top of range, transparent
        push_sample(9'd450, 10'd250,  16'sd100);
        push_sample(9'd1,   10'd1023, 16'sd5);
        push_sample(9'd89,  10'd512,  16'sd150);
        push_sample(9'd91,  10'd513,  16'sd200);
        push_sample(9'd179, 10'd3,    16'sd250);
        push_sample(9'd181, 10'd7,    16'sd300);
        push_sample(9'd269, 10'd1,    16'sd350);
        push_sample(9'd271, 10'd2,    16'sd400);
        push_sample(9'd135, 10'd651,  16'sd450);      // toward the corners
        push_sample(9'd225, 10'd650,  16'sd500);
        push_sample(9'd315, 10'd649,  16'sd550);
        push_sample(9'd256, 10'd255,  16'sd600);
    endtask

    // One random sample: mostly in-range angles and image-scale reflectivity,
    // some gates aimed at the image edge, some palette edges and raw noise.
    task automatic push_random_sample();
        int az;
        int gate;
        int refl;
        int band;
        if ($urandom_range(99) < 85) begin
            az = $urandom_range(359);
        end else begin
            az = $urandom_range(511, 360);
        end
        case ($urandom_range(3))
            0: gate = $urandom_range(15);
            1: begin
                // aim at the edge along a cardinal direction
                az = 90 * $urandom_range(3);
                if (cur_gate_len == 0) begin
                    gate = $urandom_range(1023);
                end else begin
                    gate = (cur_center * 1000) / cur_gate_len + $urandom_range(4) - 2;
                end
                if (gate < 0) gate = 0;
                if (gate > 1023) gate = 1023;
            end
            default: gate = $urandom_range(1023);
        endcase
        case ($urandom_range(9))
            0: refl = int'($signed(16'($urandom())));
            1, 2: begin
                band = $urandom_range(15);
                refl = ((band == 15) ? 9000 : -50 + 50 * band) + $urandom_range(2) - 1;
            end
            default: refl = int'($urandom_range(9200)) - 100;
        endcase
        push_sample(rpsc_pkg::AZ_W'(az), rpsc_pkg::GATE_W'(gate), rpsc_pkg::REFL_W'(refl));
    endtask

    initial begin
        int centers   [CHUNKS];
        int gate_lens [CHUNKS];

        // Drive reset, register and sample inputs to known values before the first edge
        cycle_count    <= 0;
        send_idle_pct  <= 6;
        recv_stall_pct <= 74;
        cur_center      = 460;
        cur_gate_len    = 1000;
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= rpsc_pkg::REG_CENTER;
        cfg_data       <= '0;
        smp_valid      <= 1'b0;
        smp_az         <= '0;
        smp_gate       <= '0;
        smp_refl       <= '0;

        // Register settings per chunk: extremes first, including a zero center
        // (empty image) and a zero gate length (every pixel at the center)
        centers   = '{1, 1024, 2047, 0, 300, 460, 0, 0};
        gate_lens = '{1000, 1, 1023, 250, 0, 37, 0, 0};
        for (int c = 6; c < CHUNKS; c++) begin
            centers[c]   = $urandom_range(1024, 1);
            gate_lens[c] = $urandom_range(1000, 1);
        end

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples run on the reset register values
        run_directed();

        for (int c = 0; c < CHUNKS; c++) begin
            // Pause the sender until all pixels are out, then reprogram
            drain_pixels();
            if (c < 3) begin
                send_idle_pct  <= 6;
                recv_stall_pct <= 74;
            end else if (c < 6) begin
                send_idle_pct  <= 74;
                recv_stall_pct <= 6;
            end else begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end
            load_registers(centers[c], gate_lens[c]);
            repeat (CHUNK_ITEMS) push_random_sample();
        end

        // Let the pipe run dry, then give the block time to show stray pixels
        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("PASS radar_polar_scan_convert_top");
        end else begin
            $display("FAIL radar_polar_scan_convert_top");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rpsc_pkg.sv
design/rpsc_front.sv
design/rpsc_queue.sv
design/rpsc_back.sv
design/radar_polar_scan_convert_top.sv
sim/rpsc_pixel_checker.sv
sim/tb_top.sv
